// File: hw/rtl/segment_box_clipper_unit_macros.svh
// Assertion macros for the checker of the segment box clipper.
`ifndef SEGMENT_BOX_CLIPPER_UNIT_MACROS_SVH
`define SEGMENT_BOX_CLIPPER_UNIT_MACROS_SVH

// Whenever the antecedent holds at a clock edge, the consequent must hold as well.
`define SBC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("segment box clipper check failed");

// The condition must never hold at a clock edge.
`define SBC_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("segment box clipper check failed");

`endif

// File: hw/rtl/sbc_pkg.sv
`default_nettype none
package sbc_pkg;

  // Coordinate width used when the top level is not told otherwise.
  localparam int COORD_WIDTH_DEF = 32;

  // The ratio t carries TFRAC fraction bits; it lies in -2.0 .. 2.0.
  localparam int TFRAC = 32;
  localparam int TW    = TFRAC + 3;
  localparam logic signed [TW-1:0] T_ONE = {2'b00, 1'b1, {TFRAC{1'b0}}};
  localparam logic [TFRAC+1:0]     T_SAT = {1'b1, {(TFRAC+1){1'b0}}};

  // Pipeline depths of the parts.
  localparam int DIV_LAT  = TFRAC + 2;
  localparam int CLIP_LAT = 2;
  localparam int LERP_LAT = 3;
  localparam int LATENCY  = DIV_LAT + CLIP_LAT + LERP_LAT + 2;

  // Box sides in the order in which they narrow the interval.
  localparam int NSIDE       = 4;
  localparam int SIDE_LEFT   = 0;
  localparam int SIDE_RIGHT  = 1;
  localparam int SIDE_BOTTOM = 2;
  localparam int SIDE_TOP    = 3;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_BOTTOM = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  // Per-side facts that do not need the divider.
  typedef struct packed {
    logic pz;    // direction term is zero: the segment is parallel to the side
    logic pneg;  // direction term is negative: the side can only raise t0
    logic qnn;   // distance term is not negative: the start lies inside the side
  } side_flags_t;

  typedef struct packed {
    logic                 keep;
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
  } clip_state_t;

  typedef struct packed {
    logic keep;
    logic start_moved;
    logic end_moved;
  } clip_res_t;

  // Narrow the interval against one side; a dropped segment stays dropped.
  function automatic clip_state_t clip_side(clip_state_t st, side_flags_t f,
                                            logic signed [TW-1:0] r);
    clip_state_t nx;
    nx = st;
    if (st.keep) begin
      if (f.pz) begin
        nx.keep = f.qnn;
      end else if (f.pneg) begin
        if (r > $signed(st.t1)) begin
          nx.keep = 1'b0;
        end else if (r > $signed(st.t0)) begin
          nx.t0 = r;
        end
      end else begin
        if (r < $signed(st.t0)) begin
          nx.keep = 1'b0;
        end else if (r < $signed(st.t1)) begin
          nx.t1 = r;
        end
      end
    end
    return nx;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sbc_delay.sv
`default_nettype none
// Shift line that carries a valid bit and its payload through DEPTH stages.
module sbc_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  logic             v_q [DEPTH];
  logic [WIDTH-1:0] d_q [DEPTH];

  // Valid bits are cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        v_q[i] <= 1'b0;
      end
    end else begin
      v_q[0] <= valid_i;
      for (int i = 1; i < DEPTH; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  // The payload simply follows.
  always_ff @(posedge clk_i) begin
    d_q[0] <= data_i;
    for (int i = 1; i < DEPTH; i++) begin
      d_q[i] <= d_q[i-1];
    end
  end

  assign valid_o = v_q[DEPTH-1];
  assign data_o  = d_q[DEPTH-1];

endmodule
`default_nettype wire

// File: hw/rtl/sbc_div.sv
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, truncation toward
// zero, magnitude saturated at 2.0.
module sbc_div #(
  parameter int NW = 33
) (
  input  wire logic                          clk_i,
  input  wire logic signed [NW-1:0]          num_i,
  input  wire logic signed [NW-1:0]          den_i,
  output logic signed [sbc_pkg::TW-1:0]      quo_o
);

  localparam int STEPS = sbc_pkg::TFRAC;
  localparam int QW    = STEPS + 1;

  logic [NW-1:0] un, ud, rem0;
  logic          sat, q0;

  logic [NW-1:0] rem_q [STEPS+1];
  logic [NW-1:0] ud_q  [STEPS+1];
  logic [QW-1:0] q_q   [STEPS+1];
  logic          neg_q [STEPS+1];
  logic          sat_q [STEPS+1];

  logic [sbc_pkg::TFRAC+1:0] mag;
  logic signed [sbc_pkg::TW-1:0] quo_q;

  // Magnitudes, integer bit and the saturation test.
  always_comb begin
    un   = num_i[NW-1] ? NW'(-num_i) : num_i;
    ud   = den_i[NW-1] ? NW'(-den_i) : den_i;
    sat  = {1'b0, un} >= {ud, 1'b0};
    q0   = un >= ud;
    rem0 = q0 ? un - ud : un;
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= rem0;
    ud_q[0]  <= ud;
    q_q[0]   <= QW'(q0);
    neg_q[0] <= num_i[NW-1] ^ den_i[NW-1];
    sat_q[0] <= sat;
  end

  // One fraction bit in each stage.
  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [NW:0] rem2;
    logic [NW:0] sub;
    logic        ge;

    assign rem2 = {rem_q[k-1], 1'b0};
    assign sub  = rem2 - {1'b0, ud_q[k-1]};
    assign ge   = rem2 >= {1'b0, ud_q[k-1]};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? sub[NW-1:0] : rem2[NW-1:0];
      ud_q[k]  <= ud_q[k-1];
      q_q[k]   <= {q_q[k-1][QW-2:0], ge};
      neg_q[k] <= neg_q[k-1];
      sat_q[k] <= sat_q[k-1];
    end
  end

  // Apply saturation and the sign.
  assign mag = sat_q[STEPS] ? sbc_pkg::T_SAT : {1'b0, q_q[STEPS]};

  always_ff @(posedge clk_i) begin
    quo_q <= neg_q[STEPS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign quo_o = quo_q;

endmodule
`default_nettype wire

// File: hw/rtl/sbc_clip.sv
`default_nettype none
// Interval narrowing: left and right sides in the first stage, bottom and top
// in the second. A payload rides along unchanged.
module sbc_clip #(
  parameter int PAY_W = 1
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  input  wire sbc_pkg::side_flags_t [sbc_pkg::NSIDE-1:0] side_i,
  input  wire logic signed [sbc_pkg::TW-1:0]      ratio_i [sbc_pkg::NSIDE],
  input  wire logic [PAY_W-1:0]                   pay_i,
  output logic                                    valid_o,
  output sbc_pkg::clip_res_t                      res_o,
  output logic signed [sbc_pkg::TW-1:0]           t0_o,
  output logic signed [sbc_pkg::TW-1:0]           t1_o,
  output logic [PAY_W-1:0]                        pay_o
);

  sbc_pkg::clip_state_t init_st, st_a_d, st_a_q, st_b_d, st_b_q;
  sbc_pkg::side_flags_t bot_q, top_q;
  logic signed [sbc_pkg::TW-1:0] r_bot_q, r_top_q;
  logic [PAY_W-1:0] pay_a_q, pay_b_q;
  logic v_a_q, v_b_q;

  // First stage: start from 0..1, then left and right.
  always_comb begin
    init_st.keep = 1'b1;
    init_st.t0   = '0;
    init_st.t1   = sbc_pkg::T_ONE;
    st_a_d = sbc_pkg::clip_side(init_st, side_i[sbc_pkg::SIDE_LEFT],
                                ratio_i[sbc_pkg::SIDE_LEFT]);
    st_a_d = sbc_pkg::clip_side(st_a_d, side_i[sbc_pkg::SIDE_RIGHT],
                                ratio_i[sbc_pkg::SIDE_RIGHT]);
  end

  // Second stage: bottom and top.
  always_comb begin
    st_b_d = sbc_pkg::clip_side(st_a_q, bot_q, r_bot_q);
    st_b_d = sbc_pkg::clip_side(st_b_d, top_q, r_top_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
    end else begin
      v_a_q <= valid_i;
      v_b_q <= v_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st_a_q  <= st_a_d;
    bot_q   <= side_i[sbc_pkg::SIDE_BOTTOM];
    top_q   <= side_i[sbc_pkg::SIDE_TOP];
    r_bot_q <= ratio_i[sbc_pkg::SIDE_BOTTOM];
    r_top_q <= ratio_i[sbc_pkg::SIDE_TOP];
    pay_a_q <= pay_i;
    st_b_q  <= st_b_d;
    pay_b_q <= pay_a_q;
  end

  assign valid_o           = v_b_q;
  assign res_o.keep        = st_b_q.keep;
  assign res_o.start_moved = $signed(st_b_q.t0) > 0;
  assign res_o.end_moved   = $signed(st_b_q.t1) < sbc_pkg::T_ONE;
  assign t0_o              = st_b_q.t0;
  assign t1_o              = st_b_q.t1;
  assign pay_o             = pay_b_q;

endmodule
`default_nettype wire

// File: hw/rtl/sbc_lerp.sv
`default_nettype none
// Moves one coordinate to a + round(t * d) over three stages: two partial
// products, their rounded sum, then the add or subtract.
module sbc_lerp #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic signed [COORD_WIDTH-1:0] base_i,
  input  wire logic signed [COORD_WIDTH:0]   delta_i,
  input  wire logic signed [sbc_pkg::TW-1:0] t_i,
  input  wire logic                          move_i,
  output logic signed [COORD_WIDTH-1:0]      coord_o
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int HW = (DW > 32) ? DW - 32 : 1;
  localparam int UW = 32 + HW;
  localparam int TU = sbc_pkg::TFRAC + 1;
  localparam int PW = HW + 34;

  logic [DW-1:0]      ud;
  logic [UW-1:0]      ud_pad;
  logic [TU-1:0]      ut;
  logic [TU+31:0]     plo_q;
  logic [HW+TU-1:0]   phi_q;
  logic [TU+32:0]     lo_rnd;
  logic [PW-1:0]      prod_d, prod_q;
  logic signed [COORD_WIDTH-1:0] base_a_q, base_b_q, coord_q;
  logic dneg_a_q, dneg_b_q, move_a_q, move_b_q;
  logic signed [DW-1:0] sum_ext;

  // Partial products of |d| split at bit 32.
  assign ud     = delta_i[DW-1] ? DW'(-delta_i) : delta_i;
  assign ud_pad = UW'(ud);
  assign ut     = t_i[TU-1:0];

  always_ff @(posedge clk_i) begin
    plo_q    <= ud_pad[31:0] * ut;
    phi_q    <= ud_pad[UW-1:32] * ut;
    base_a_q <= base_i;
    dneg_a_q <= delta_i[DW-1];
    move_a_q <= move_i;
  end

  // Round the low product to whole output units and add the high one.
  assign lo_rnd = {1'b0, plo_q} + (TU+33)'(64'h8000_0000);
  assign prod_d = PW'(phi_q) + PW'(lo_rnd[TU+32:32]);

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    base_b_q <= base_a_q;
    dneg_b_q <= dneg_a_q;
    move_b_q <= move_a_q;
  end

  // Step from the base towards the other end; the result stays in range.
  always_comb begin
    if (dneg_b_q) begin
      sum_ext = DW'(base_b_q) - $signed(prod_q[DW-1:0]);
    end else begin
      sum_ext = DW'(base_b_q) + $signed(prod_q[DW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q <= move_b_q ? sum_ext[COORD_WIDTH-1:0] : base_b_q;
  end

  assign coord_o = coord_q;

endmodule
`default_nettype wire

// File: hw/rtl/segment_box_clipper_unit.sv
`default_nettype none
// Segment box clipper: clips one line segment against an axis-aligned box.
// The box is set through the APB-style port: left, right, bottom and top at
// register indexes 0 to 3, signed Q16.16, all zero after reset. Write the box
// only while no segment is in flight.
// A segment is taken when start is high and busy is low; busy is never
// raised, so a new segment may be offered in every cycle.
// Every segment yields one result, shown for one cycle with done_o high. The
// result passes through 41 stages: the input register, the four side dividers
// (34 stages: the magnitude stage, one quotient bit per stage and the sign
// stage), the two interval stages, the three interpolation stages and the
// result register. Throughput is one segment per clock cycle.
// A rejected segment gives visible_o low and all other result fields zero.
// start_moved_o and end_moved_o tell which end was pulled into the box.
// Reset clears the box and every in-flight segment; no result is shown for
// a segment that was in flight at reset. The receiver cannot hold results
// off, and the block never needs it to.
module segment_box_clipper_unit #(
  parameter int COORD_WIDTH = sbc_pkg::COORD_WIDTH_DEF,
  localparam int PDATA_W    = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int PADDR_W    = (COORD_WIDTH > 32) ? 5 : 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] start_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_y_i,
  output logic                               done_o,
  output logic                               visible_o,
  output logic signed [COORD_WIDTH-1:0]      out_start_x_o,
  output logic signed [COORD_WIDTH-1:0]      out_start_y_o,
  output logic signed [COORD_WIDTH-1:0]      out_end_x_o,
  output logic signed [COORD_WIDTH-1:0]      out_end_y_o,
  output logic                               start_moved_o,
  output logic                               end_moved_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [PADDR_W-1:0]            paddr,
  input  wire logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]                 prdata,
  output logic                               pready
);

  localparam int W     = COORD_WIDTH;
  localparam int DW    = COORD_WIDTH + 1;
  localparam int FLG_W = $bits(sbc_pkg::side_flags_t) * sbc_pkg::NSIDE;
  localparam int PAY_W = 2 * W + 2 * DW;

  // Configuration registers.
  logic signed [W-1:0] left_q, right_q, bottom_q, top_q;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  assign reg_idx = paddr[PADDR_W-1:PADDR_W-2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      right_q  <= '0;
      bottom_q <= '0;
      top_q    <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        sbc_pkg::REG_LEFT:   left_q   <= pwdata[W-1:0];
        sbc_pkg::REG_RIGHT:  right_q  <= pwdata[W-1:0];
        sbc_pkg::REG_BOTTOM: bottom_q <= pwdata[W-1:0];
        sbc_pkg::REG_TOP:    top_q    <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sbc_pkg::REG_LEFT:   prdata = PDATA_W'(left_q);
      sbc_pkg::REG_RIGHT:  prdata = PDATA_W'(right_q);
      sbc_pkg::REG_BOTTOM: prdata = PDATA_W'(bottom_q);
      sbc_pkg::REG_TOP:    prdata = PDATA_W'(top_q);
      default:             prdata = '0;
    endcase
  end

  // Input stage: differences and the side terms, all exact at W+1 bits.
  logic accept;
  logic signed [DW-1:0] sx_e, sy_e, dx_d, dy_d;
  logic signed [DW-1:0] p_d [sbc_pkg::NSIDE];
  logic signed [DW-1:0] q_d [sbc_pkg::NSIDE];
  logic signed [DW-1:0] p_q [sbc_pkg::NSIDE];
  logic signed [DW-1:0] q_q [sbc_pkg::NSIDE];
  logic signed [W-1:0]  sx_q, sy_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic                 v1_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    sx_e = DW'(start_x_i);
    sy_e = DW'(start_y_i);
    dx_d = DW'(end_x_i) - sx_e;
    dy_d = DW'(end_y_i) - sy_e;
    p_d[sbc_pkg::SIDE_LEFT]   = -dx_d;
    q_d[sbc_pkg::SIDE_LEFT]   = sx_e - DW'(left_q);
    p_d[sbc_pkg::SIDE_RIGHT]  = dx_d;
    q_d[sbc_pkg::SIDE_RIGHT]  = DW'(right_q) - sx_e;
    p_d[sbc_pkg::SIDE_BOTTOM] = -dy_d;
    q_d[sbc_pkg::SIDE_BOTTOM] = sy_e - DW'(bottom_q);
    p_d[sbc_pkg::SIDE_TOP]    = dy_d;
    q_d[sbc_pkg::SIDE_TOP]    = DW'(top_q) - sy_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < sbc_pkg::NSIDE; i++) begin
      p_q[i] <= p_d[i];
      q_q[i] <= q_d[i];
    end
    sx_q <= start_x_i;
    sy_q <= start_y_i;
    dx_q <= dx_d;
    dy_q <= dy_d;
  end

  // One divider per side, plus the flags that settle parallel sides.
  logic signed [sbc_pkg::TW-1:0] ratio [sbc_pkg::NSIDE];
  sbc_pkg::side_flags_t [sbc_pkg::NSIDE-1:0] flg_d, flg_dly;

  for (genvar s = 0; s < sbc_pkg::NSIDE; s++) begin : g_side
    sbc_div #(.NW(DW)) u_div (
      .clk_i (clk_i),
      .num_i (q_q[s]),
      .den_i (p_q[s]),
      .quo_o (ratio[s])
    );
    assign flg_d[s].pz   = p_q[s] == '0;
    assign flg_d[s].pneg = p_q[s][DW-1];
    assign flg_d[s].qnn  = !q_q[s][DW-1];
  end

  // Segment data waits alongside the dividers.
  logic             v_div;
  logic [PAY_W-1:0] pay_d, pay_div, pay_clip;

  assign pay_d = {sx_q, sy_q, dx_q, dy_q};

  sbc_delay #(.WIDTH(FLG_W + PAY_W), .DEPTH(sbc_pkg::DIV_LAT)) u_div_dly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .data_i  ({flg_d, pay_d}),
    .valid_o (v_div),
    .data_o  ({flg_dly, pay_div})
  );

  // Interval narrowing.
  logic                          v_clip;
  sbc_pkg::clip_res_t            res_clip, res_dly;
  logic signed [sbc_pkg::TW-1:0] t0, t1;

  sbc_clip #(.PAY_W(PAY_W)) u_clip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_div),
    .side_i  (flg_dly),
    .ratio_i (ratio),
    .pay_i   (pay_div),
    .valid_o (v_clip),
    .res_o   (res_clip),
    .t0_o    (t0),
    .t1_o    (t1),
    .pay_o   (pay_clip)
  );

  logic signed [W-1:0]  c_sx, c_sy;
  logic signed [DW-1:0] c_dx, c_dy;

  assign {c_sx, c_sy, c_dx, c_dy} = pay_clip;

  // Endpoint interpolation, one unit per output coordinate. The end units
  // always step from the start, so t1 of one lands exactly on the end point.
  logic signed [W-1:0] lx0, ly0, lx1, ly1;

  sbc_lerp #(.COORD_WIDTH(W)) u_lerp_sx (
    .clk_i (clk_i), .base_i (c_sx), .delta_i (c_dx), .t_i (t0),
    .move_i (res_clip.start_moved), .coord_o (lx0)
  );
  sbc_lerp #(.COORD_WIDTH(W)) u_lerp_sy (
    .clk_i (clk_i), .base_i (c_sy), .delta_i (c_dy), .t_i (t0),
    .move_i (res_clip.start_moved), .coord_o (ly0)
  );
  sbc_lerp #(.COORD_WIDTH(W)) u_lerp_ex (
    .clk_i (clk_i), .base_i (c_sx), .delta_i (c_dx), .t_i (t1),
    .move_i (1'b1), .coord_o (lx1)
  );
  sbc_lerp #(.COORD_WIDTH(W)) u_lerp_ey (
    .clk_i (clk_i), .base_i (c_sy), .delta_i (c_dy), .t_i (t1),
    .move_i (1'b1), .coord_o (ly1)
  );

  logic v_lerp;

  sbc_delay #(.WIDTH($bits(sbc_pkg::clip_res_t)), .DEPTH(sbc_pkg::LERP_LAT)) u_res_dly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_clip),
    .data_i  (res_clip),
    .valid_o (v_lerp),
    .data_o  (res_dly)
  );

  // Result register: a rejected segment shows zeros.
  logic                done_q, vis_q, smv_q, emv_q;
  logic signed [W-1:0] osx_q, osy_q, oex_q, oey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v_lerp;
    end
  end

  always_ff @(posedge clk_i) begin
    vis_q <= res_dly.keep;
    smv_q <= res_dly.keep && res_dly.start_moved;
    emv_q <= res_dly.keep && res_dly.end_moved;
    osx_q <= res_dly.keep ? lx0 : '0;
    osy_q <= res_dly.keep ? ly0 : '0;
    oex_q <= res_dly.keep ? lx1 : '0;
    oey_q <= res_dly.keep ? ly1 : '0;
  end

  assign done_o        = done_q;
  assign visible_o     = vis_q;
  assign start_moved_o = smv_q;
  assign end_moved_o   = emv_q;
  assign out_start_x_o = osx_q;
  assign out_start_y_o = osy_q;
  assign out_end_x_o   = oex_q;
  assign out_end_y_o   = oey_q;

endmodule
`default_nettype wire

// File: hw/rtl/sbc_checker.sv
`default_nettype none
`include "segment_box_clipper_unit_macros.svh"
// Port-level checks on the segment box clipper.
module sbc_checker #(
  parameter int COORD_WIDTH = sbc_pkg::COORD_WIDTH_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic signed [COORD_WIDTH-1:0] start_x_i,
  input wire logic signed [COORD_WIDTH-1:0] start_y_i,
  input wire logic signed [COORD_WIDTH-1:0] end_x_i,
  input wire logic signed [COORD_WIDTH-1:0] end_y_i,
  input wire logic                          done_o,
  input wire logic                          visible_o,
  input wire logic signed [COORD_WIDTH-1:0] out_start_x_o,
  input wire logic signed [COORD_WIDTH-1:0] out_start_y_o,
  input wire logic signed [COORD_WIDTH-1:0] out_end_x_o,
  input wire logic signed [COORD_WIDTH-1:0] out_end_y_o,
  input wire logic                          start_moved_o,
  input wire logic                          end_moved_o
);

  // Every result beat answers a segment taken a fixed time earlier, and back.
  `SBC_ASSERT_IMPL(a_done_has_src, done_o, $past(start && !busy, sbc_pkg::LATENCY))
  `SBC_ASSERT_IMPL(a_src_has_done, $past(start && !busy, sbc_pkg::LATENCY), done_o)

  // A rejected segment shows nothing else.
  `SBC_ASSERT_NEVER(a_reject_clean, done_o && !visible_o && (start_moved_o || end_moved_o || out_start_x_o != 0 || out_start_y_o != 0 || out_end_x_o != 0 || out_end_y_o != 0))

  // An end that did not move is passed through unchanged.
  `SBC_ASSERT_IMPL(a_start_kept, done_o && visible_o && !start_moved_o, out_start_x_o == $past(start_x_i, sbc_pkg::LATENCY) && out_start_y_o == $past(start_y_i, sbc_pkg::LATENCY))
  `SBC_ASSERT_IMPL(a_end_kept, done_o && visible_o && !end_moved_o, out_end_x_o == $past(end_x_i, sbc_pkg::LATENCY) && out_end_y_o == $past(end_y_i, sbc_pkg::LATENCY))

endmodule

bind segment_box_clipper_unit sbc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sbc_checker (.*);
`default_nettype wire

// File: dv/tb_segment_box_clipper_unit.sv
`timescale 1ns / 1ps

module tb_segment_box_clipper_unit;

  localparam int CW = 32;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic signed [63:0] T_UNIT = 64'sd1 << 32;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
  } segment_t;

  typedef struct packed {
    logic                 visible;
    logic signed [CW-1:0] osx;
    logic signed [CW-1:0] osy;
    logic signed [CW-1:0] oex;
    logic signed [CW-1:0] oey;
    logic                 smoved;
    logic                 emoved;
  } clipped_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic busy_q = 1'b0;
  logic signed [CW-1:0] start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic done_o, visible_o, start_moved_o, end_moved_o;
  logic signed [CW-1:0] out_start_x_o, out_start_y_o, out_end_x_o, out_end_y_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  segment_box_clipper_unit u_top (.*);

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Box held by the predictor, in step with the register writes.
  logic signed [63:0] bx_lo, bx_hi, by_lo, by_hi;

  segment_t pending_segments[$];
  clipped_t expected_clips[$];
  int errors = 0;
  int seg_sent = 0, clips_seen = 0, clips_visible = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit timed_out = 1'b0;

  // Signed ratio num/den with 32 fraction bits, truncated, saturating at 2.0.
  function automatic logic signed [63:0] t_ratio(logic signed [63:0] num,
                                                 logic signed [63:0] den);
    logic [63:0] un, ud, q, rem;
    bit neg;
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    neg = (num < 0) != (den < 0);
    if (un >= ud && un - ud >= ud) begin
      q = 64'd2 << 32;
    end else begin
      q = un >= ud ? 64'd1 : 64'd0;
      rem = un >= ud ? un - ud : un;
      for (int i = 0; i < 32; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= ud) begin
          rem = rem - ud;
          q[0] = 1'b1;
        end
      end
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // Narrow t0..t1 against one side; returns 0 when the segment is dropped.
  function automatic bit narrow(logic signed [63:0] p, logic signed [63:0] q,
                                inout logic signed [63:0] t0,
                                inout logic signed [63:0] t1);
    logic signed [63:0] r;
    if (p == 0) return q >= 0;
    r = t_ratio(q, p);
    if (p < 0) begin
      if (r > t1) return 0;
      if (r > t0) t0 = r;
    end else begin
      if (r < t0) return 0;
      if (r < t1) t1 = r;
    end
    return 1;
  endfunction

  // Point a + round(t*d), half rounding away from zero in magnitude.
  function automatic logic signed [63:0] along(logic signed [63:0] a,
                                               logic signed [63:0] d,
                                               logic signed [63:0] t);
    logic [63:0] ud, hi, lo, prod;
    ud = d < 0 ? -d : d;
    hi = ud >> 32;
    lo = ud & 64'hFFFF_FFFF;
    prod = hi * t + ((lo * t + (64'd1 << 31)) >> 32);
    return d < 0 ? a - $signed(prod) : a + $signed(prod);
  endfunction

  function automatic clipped_t clip_segment(segment_t s);
    logic signed [63:0] sx, sy, ex, ey, dx, dy, t0, t1;
    clipped_t c;
    bit keep;
    sx = 64'(s.sx); sy = 64'(s.sy); ex = 64'(s.ex); ey = 64'(s.ey);
    dx = ex - sx; dy = ey - sy;
    t0 = 0; t1 = T_UNIT;
    c = '0;
    keep = narrow(-dx, sx - bx_lo, t0, t1);
    if (keep) keep = narrow(dx, bx_hi - sx, t0, t1);
    if (keep) keep = narrow(-dy, sy - by_lo, t0, t1);
    if (keep) keep = narrow(dy, by_hi - sy, t0, t1);
    if (!keep) return c;
    c.visible = 1'b1;
    c.osx = CW'((t0 > 0) ? along(sx, dx, t0) : sx);
    c.osy = CW'((t0 > 0) ? along(sy, dy, t0) : sy);
    c.oex = CW'((t1 < T_UNIT) ? along(sx, dx, t1) : ex);
    c.oey = CW'((t1 < T_UNIT) ? along(sy, dy, t1) : ey);
    c.smoved = t0 > 0;
    c.emoved = t1 < T_UNIT;
    return c;
  endfunction

  // Driver: offers queued segments at the falling edge, with random gaps unless calm is set.
  always @(negedge clk_i) begin
    if (start && !busy_q) begin
      void'(pending_segments.pop_front());
    end
    if (rst_ni && pending_segments.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
      start <= 1'b1;
      {start_x_i, start_y_i, end_x_i, end_y_i} <= pending_segments[0];
    end else begin
      start <= 1'b0;
    end
  end

  // busy sampled at the rising edge decides whether the offered beat was taken.
  always @(posedge clk_i) begin
    busy_q <= busy;
    if (rst_ni && start && !busy) begin
      expected_clips.insert(expected_clips.size(),
                            clip_segment({start_x_i, start_y_i, end_x_i, end_y_i}));
      seg_sent++;
    end
  end

  // Monitor: checks each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    clipped_t exp_c;
    if (rst_ni && done_o) begin
      clips_seen++;
      if (expected_clips.size() == 0) begin
        $error("result beat with no segment outstanding");
        errors++;
      end else begin
        exp_c = expected_clips.pop_front();
        if (visible_o !== exp_c.visible) begin
          $error("visible: expected %0d, got %0d", exp_c.visible, visible_o); errors++;
        end
        if (out_start_x_o !== exp_c.osx) begin
          $error("out_start_x: expected %0d, got %0d", exp_c.osx, out_start_x_o); errors++;
        end
        if (out_start_y_o !== exp_c.osy) begin
          $error("out_start_y: expected %0d, got %0d", exp_c.osy, out_start_y_o); errors++;
        end
        if (out_end_x_o !== exp_c.oex) begin
          $error("out_end_x: expected %0d, got %0d", exp_c.oex, out_end_x_o); errors++;
        end
        if (out_end_y_o !== exp_c.oey) begin
          $error("out_end_y: expected %0d, got %0d", exp_c.oey, out_end_y_o); errors++;
        end
        if (start_moved_o !== exp_c.smoved) begin
          $error("start_moved: expected %0d, got %0d", exp_c.smoved, start_moved_o); errors++;
        end
        if (end_moved_o !== exp_c.emoved) begin
          $error("end_moved: expected %0d, got %0d", exp_c.emoved, end_moved_o); errors++;
        end
        if (exp_c.visible) clips_visible++;
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves while work is outstanding.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o ||
        (pending_segments.size() == 0 && expected_clips.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic signed [CW-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      sbc_pkg::REG_LEFT:   bx_lo = 64'(val);
      sbc_pkg::REG_RIGHT:  bx_hi = 64'(val);
      sbc_pkg::REG_BOTTOM: by_lo = 64'(val);
      default:             by_hi = 64'(val);
    endcase
  endtask

  task automatic set_box(logic signed [CW-1:0] l, logic signed [CW-1:0] r,
                         logic signed [CW-1:0] b, logic signed [CW-1:0] t);
    reg_write(sbc_pkg::REG_LEFT, l);
    reg_write(sbc_pkg::REG_RIGHT, r);
    reg_write(sbc_pkg::REG_BOTTOM, b);
    reg_write(sbc_pkg::REG_TOP, t);
  endtask

  // Waits until every segment has come back, then lets the pipeline drain.
  task automatic drain();
    while ((pending_segments.size() > 0 || expected_clips.size() > 0) && !timed_out)
      @(posedge clk_i);
    repeat (sbc_pkg::LATENCY + 8) @(posedge clk_i);
  endtask

  // Coordinate: mostly near the box, sometimes anywhere or at an extreme.
  function automatic logic signed [CW-1:0] coord();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(32'h0006_0000)) - 32'sh0003_0000;
    endcase
  endfunction

  task automatic add_seg(logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                         logic signed [CW-1:0] ex, logic signed [CW-1:0] ey);
    pending_segments.insert(pending_segments.size(), {sx, sy, ex, ey});
  endtask

  task automatic random_phase(int n);
    logic signed [CW-1:0] x, y;
    for (int i = 0; i < n; i++) begin
      x = coord(); y = coord();
      case ($urandom_range(7))
        0: add_seg(x, y, x, y);                 // single point
        1: add_seg(x, y, x, coord());           // vertical
        2: add_seg(x, y, coord(), y);           // horizontal
        default: add_seg(x, y, coord(), coord());
      endcase
    end
    drain();
  endtask

  localparam logic signed [CW-1:0] ONE = 32'sh0001_0000;
  localparam logic signed [CW-1:0] MAXC = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] MINC = 32'sh8000_0000;

  initial begin
    bx_lo = 0; bx_hi = 0; by_lo = 0; by_hi = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset box first, then a unit box.
    add_seg(0, 0, 0, 0);
    add_seg(-ONE, 0, ONE, 0);
    drain();
    set_box(-ONE, ONE, -ONE, ONE);
    calm = 1'b1;
    add_seg(-2 * ONE, 0, 2 * ONE, 0);           // both ends move
    add_seg(0, 0, ONE / 2, ONE / 2);            // inside, no move
    add_seg(2 * ONE, 0, 2 * ONE, ONE);          // parallel, outside right
    add_seg(-2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE); // parallel, above
    add_seg(-2 * ONE, 0, 0, 3 * ONE);           // misses the corner
    add_seg(-2 * ONE, 0, 0, 2 * ONE);           // touches a corner
    add_seg(2 * ONE, 2 * ONE, -2 * ONE, -2 * ONE); // diagonal, reversed
    add_seg(0, 0, 0, 0);                        // point inside
    add_seg(3 * ONE, 0, 3 * ONE, 0);            // point outside
    add_seg(MINC, MINC, MAXC, MAXC);            // extremes
    add_seg(MAXC, MINC, MINC, MAXC);
    add_seg(MAXC, MAXC, MAXC, MAXC);
    add_seg(-ONE, -ONE, ONE, ONE);              // on the box edges
    add_seg(32'sh0000_0001, 32'shFFFF_FFFF, 32'h0001_5555, 32'sh0000_AAAA);
    drain();
    calm = 1'b0;

    // Random phases over several boxes, including the widest and an inverted one.
    random_phase(150);
    set_box(MINC, MAXC, MINC, MAXC);
    random_phase(60);
    set_box(ONE, -ONE, -ONE, ONE);
    random_phase(40);
    set_box($signed($urandom_range(32'h0002_0000)) - 32'sh0002_0000,
            $urandom_range(32'h0002_0000), -32'sh0000_8000, 32'sh0000_4000);
    calm = 1'b1;
    random_phase(80);
    calm = 1'b0;
    set_box(-3 * ONE, 3 * ONE, -ONE, 2 * ONE);
    random_phase(100);

    $display("Clipped %0d segments (%0d visible) across six box settings.",
             clips_seen, clips_visible);
    if (errors == 0 && !timed_out) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Stops a hung run.
  initial begin
    wait (timed_out);
    $display("Run stopped: no beat moved for too long.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
